### hdl/text_console_cursor_engine_defines.svh
// Assertion macros shared by the console engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define TCCE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tcce_pkg.sv
package tcce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int POS_W  = 12;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int KEY_W  = 3;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 2 * CHAR_W;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

	localparam logic [KEY_W-1:0] ARROW_UP    = 3'd1;
	localparam logic [KEY_W-1:0] ARROW_DOWN  = 3'd2;
	localparam logic [KEY_W-1:0] ARROW_LEFT  = 3'd3;
	localparam logic [KEY_W-1:0] ARROW_RIGHT = 3'd4;

	localparam logic [CHAR_W-1:0] CODE_NONE      = 8'h00;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
	localparam logic [CHAR_W-1:0] CLEAR_ATTR     = 8'h07;
	localparam logic [CHAR_W-1:0] SCROLL_ATTR    = 8'h0F;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              ovf;
	} char_upd_t;

	function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_pos = POS_W'(r) * POS_W'(COLUMNS) + POS_W'(c);
	endfunction

endpackage

### hdl/tcce_ram.sv
module tcce_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/tcce_cursor.sv
module tcce_cursor (
	input  logic [tcce_pkg::ROW_W-1:0]  row,
	input  logic [tcce_pkg::COL_W-1:0]  col,
	input  logic [tcce_pkg::CHAR_W-1:0] char_code,
	input  logic [tcce_pkg::CHAR_W-1:0] color,
	input  logic [tcce_pkg::KEY_W-1:0]  key_code,
	output tcce_pkg::char_upd_t         upd
);
	import tcce_pkg::*;

	logic [ROW_W-1:0]  r;
	logic [COL_W-1:0]  c;
	logic [ROW_W-1:0]  wr;
	logic [COL_W-1:0]  wc;
	logic [CHAR_W-1:0] wch;
	logic              we;
	logic              ovf;

	always_comb begin
		r   = row;
		c   = col;
		wr  = row;
		wc  = col;
		wch = char_code;
		we  = 1'b0;
		ovf = 1'b0;

		if (char_code == CODE_BACKSPACE) begin
			if (c != '0) begin
				c = c - 1'b1;
			end else if (r != '0) begin
				r = r - 1'b1;
				c = COL_W'(COLUMNS - 1);
			end
			wr  = r;
			wc  = c;
			wch = BLANK_CHAR;
			we  = (r < ROW_W'(ROWS));
			ovf = !we;
		end else if (char_code == CODE_NEWLINE) begin
			if (r >= ROW_W'(ROWS)) begin
				r   = ROW_W'(ROWS);
				ovf = 1'b1;
			end else begin
				r = r + 1'b1;
			end
			c = '0;
		end else if (char_code != CODE_NONE) begin
			we  = (r < ROW_W'(ROWS));
			ovf = !we;
			if (c == COL_W'(COLUMNS - 1)) begin
				c = '0;
				if (r >= ROW_W'(ROWS)) begin
					r   = ROW_W'(ROWS);
					ovf = 1'b1;
				end else begin
					r = r + 1'b1;
				end
			end else begin
				c = c + 1'b1;
			end
		end

		if (key_code == ARROW_UP) begin
			if (r != '0) begin
				r = r - 1'b1;
			end
		end else if (key_code == ARROW_DOWN) begin
			if (r < ROW_W'(ROWS - 1)) begin
				r = r + 1'b1;
			end
		end else if (key_code == ARROW_LEFT) begin
			if (c != '0) begin
				c = c - 1'b1;
			end else if (r != '0) begin
				r = r - 1'b1;
				c = COL_W'(COLUMNS - 1);
			end
		end else if (key_code == ARROW_RIGHT) begin
			if (c < COL_W'(COLUMNS - 1)) begin
				c = c + 1'b1;
			end else if (r < ROW_W'(ROWS - 1)) begin
				r = r + 1'b1;
				c = '0;
			end
		end

		upd.row   = r;
		upd.col   = c;
		upd.we    = we;
		upd.waddr = ADDR_W'(cell_pos(wr, wc));
		upd.wdata = {wch, color};
		upd.ovf   = ovf;
	end

endmodule

### hdl/text_console_cursor_engine.sv
// Text console engine with an 80x25 store of character and attribute cells and a
// cursor. An item is taken when start is high and busy is low; its single result
// appears on the result ports for exactly one cycle, marked by done, and the
// receiver cannot stall it. The cell store is one memory with one write port and
// one read port, so the cost of an item is set by how many cells it touches:
// a character item or a read item passes through ST_CHAR or ST_READ to ST_DONE,
// a scroll item with a cursor row under 24 goes straight to ST_DONE, a scroll
// runs a one-cell-per-cycle copy of 24 rows and then a blank of one row, and
// a clear fills all 2000 cells in turn. A new item may be taken in the cycle
// that shows a result. After reset the block runs a clearing pass over all 2000
// cells with busy high and gives no result for it.
`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tcce_pkg::KIND_W-1:0] kind,
	input  logic [tcce_pkg::CHAR_W-1:0] char_code,
	input  logic [tcce_pkg::CHAR_W-1:0] color,
	input  logic [tcce_pkg::KEY_W-1:0]  key_code,
	input  logic [tcce_pkg::IDX_W-1:0]  cell_index,
	output logic                        done,
	output logic [tcce_pkg::ROW_W-1:0]  cursor_row,
	output logic [tcce_pkg::COL_W-1:0]  cursor_col,
	output logic [tcce_pkg::POS_W-1:0]  cursor_position,
	output logic [tcce_pkg::CHAR_W-1:0] cell_char,
	output logic [tcce_pkg::CHAR_W-1:0] cell_attr,
	output logic                        row_overflow
);
	import tcce_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CHAR   = 7'b0000010,
		ST_READ   = 7'b0000100,
		ST_SCROLL = 7'b0001000,
		ST_BLANK  = 7'b0010000,
		ST_FILL   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              ovf_q;
	logic              rd_ok_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] char_q;
	logic [CHAR_W-1:0] color_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  idx_q;

	logic              accept;
	char_upd_t         upd;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [CELL_W-1:0] rdata;

	assign busy   = !(state_q == ST_IDLE || state_q == ST_DONE);
	assign accept = start && !busy;
	assign done   = (state_q == ST_DONE);

	tcce_cursor u_cursor (
		.row       (row_q),
		.col       (col_q),
		.char_code (char_q),
		.color     (color_q),
		.key_code  (key_q),
		.upd       (upd)
	);

	tcce_ram #(
		.DEPTH (CELLS),
		.WIDTH (CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A scroll copy lands in the cycle after its read and takes the write port first.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = {CODE_NONE, CLEAR_ATTR};
		if (pend_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = rdata;
		end else begin
			unique case (state_q)
				ST_CHAR: begin
					we    = upd.we;
					waddr = upd.waddr;
					wdata = upd.wdata;
				end
				ST_BLANK: begin
					we    = 1'b1;
					waddr = ADDR_W'(cell_pos(row_q, COL_W'(0))) + cnt_q;
					wdata = {BLANK_CHAR, SCROLL_ATTR};
				end
				ST_FILL: begin
					we = 1'b1;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	assign re    = (state_q == ST_SCROLL) || (state_q == ST_READ && rd_ok_q);
	assign raddr = (state_q == ST_SCROLL) ? cnt_q : idx_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			char_q  <= char_code;
			color_q <= color;
			key_q   <= key_code;
			idx_q   <= cell_index;
		end
		waddr_s1 <= cnt_q - ADDR_W'(COLUMNS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			init_q  <= 1'b1;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			ovf_q   <= 1'b0;
			rd_ok_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_IDLE, ST_DONE: begin
					if (start) begin
						ovf_q   <= 1'b0;
						rd_ok_q <= (kind == KIND_READ) && (cell_index < IDX_W'(CELLS));
						unique case (kind)
							KIND_CHAR: begin
								state_q <= ST_CHAR;
							end
							KIND_SCROLL: begin
								if (row_q >= ROW_W'(ROWS - 1)) begin
									row_q   <= row_q - 1'b1;
									col_q   <= '0;
									cnt_q   <= ADDR_W'(COLUMNS);
									state_q <= ST_SCROLL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							KIND_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							KIND_READ: begin
								state_q <= ST_READ;
							end
						endcase
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHAR: begin
					row_q   <= upd.row;
					col_q   <= upd.col;
					ovf_q   <= upd.ovf;
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					if (cnt_q == ADDR_W'(CELLS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (!pend_s1) begin
						if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_FILL: begin
					if (cnt_q == ADDR_W'(CELLS - 1)) begin
						cnt_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cursor_row      = row_q;
	assign cursor_col      = col_q;
	assign cursor_position = cell_pos(row_q, col_q);
	assign cell_char       = rd_ok_q ? rdata[CELL_W-1:CHAR_W] : CODE_NONE;
	assign cell_attr       = rd_ok_q ? rdata[CHAR_W-1:0] : CODE_NONE;
	assign row_overflow    = ovf_q;

	`TCCE_ASSERT_ALWAYS(a_row_range, row_q <= ROW_W'(ROWS), "cursor row beyond saturation")
	`TCCE_ASSERT_ALWAYS(a_col_range, col_q < COL_W'(COLUMNS), "cursor column off the screen")
	`TCCE_ASSERT_IMP(a_write_range, we, waddr < ADDR_W'(CELLS), "cell write outside the store")
	`TCCE_ASSERT_NEXT(a_single_beat, done && !start, !done, "result beat repeated")
	`TCCE_ASSERT_IMP(a_ovf_kind, done && kind_q != KIND_CHAR, !row_overflow, "overflow on a non-character item")

endmodule
